>>> hw/rtl/carrier_script_part_parser_defines.svh
// assertion helpers used by the rtl queue
`ifndef CARRIER_SCRIPT_PART_PARSER_DEFINES_SVH
`define CARRIER_SCRIPT_PART_PARSER_DEFINES_SVH

// property checked on every clock outside reset
`define CSPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define CSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/cspp_pkg.sv
package cspp_pkg;

  localparam int CHUNK_COUNT = 5;
  localparam logic [15:0] CHUNK_LIMIT = 16'd520;

  localparam int FP_W = $clog2(CHUNK_COUNT + 4);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_REDEEM  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_BAD_OP     = 3'd2,
    ST_TAG_LEN    = 3'd3,
    ST_HDR_LEN    = 3'd4,
    ST_VERSION    = 3'd5,
    ST_CHUNK_LONG = 3'd6
  } status_e;

  typedef struct packed {
    logic        data_vld;
    kind_e       data_kind;
    logic [7:0]  data_byte;
    logic        sum_vld;
    logic [63:0] tag;
    logic [7:0]  part;
    logic [7:0]  parts;
    logic [15:0] key_len;
    logic [15:0] whole_len;
    logic [11:0] pay_cnt;
    logic [15:0] red_cnt;
    status_e     status;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hw/rtl/cspp_front.sv
module cspp_front
  import cspp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] script_byte_i,
  input  logic       end_of_script_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  q_stat_t    q_stat_i,
  output logic       push_o,
  output q_entry_t   entry_o
);

  typedef enum logic [1:0] {
    PP_OP   = 2'd0,
    PP_LEN  = 2'd1,
    PP_HI   = 2'd2,
    PP_DATA = 2'd3
  } push_phase_e;

  localparam logic [7:0] OP_DIRECT_MAX = 8'd75;
  localparam logic [7:0] OP_LEN8       = 8'h4c;
  localparam logic [7:0] OP_LEN16      = 8'h4d;
  localparam logic [7:0] HDR_VERSION   = 8'h01;
  localparam logic [15:0] FIELD_LEN    = 16'd8;

  localparam logic [FP_W-1:0] FP_TAG    = '0;
  localparam logic [FP_W-1:0] FP_HDR    = FP_W'(1);
  localparam logic [FP_W-1:0] FP_CHUNK0 = FP_W'(2);
  localparam logic [FP_W-1:0] FP_REDEEM = FP_W'(2 + CHUNK_COUNT);
  localparam logic [FP_W-1:0] FP_DONE   = FP_W'(3 + CHUNK_COUNT);
  localparam logic [FP_W-1:0] FP_ONE    = FP_W'(1);

  logic [FP_W-1:0] fp_q, fp_d;
  push_phase_e     pp_q, pp_d;
  logic [15:0]     bl_q, bl_d;
  logic [15:0]     pl_q, pl_d;
  logic [63:0]     tag_q, tag_d;
  logic [7:0]      hv_q, hv_d;
  logic [7:0]      idx_q, idx_d;
  logic [7:0]      tot_q, tot_d;
  logic [15:0]     key_q, key_d;
  logic [15:0]     whole_q, whole_d;
  logic [11:0]     pc_q, pc_d;
  logic [15:0]     rc_q, rc_d;
  status_e         err_q, err_d;

  logic        acc;
  logic        start_en;
  logic [15:0] start_len;
  logic        fin;
  logic        emit;
  kind_e       emit_kind;
  logic [15:0] off;
  status_e     st;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && (emit || end_of_script_i);

  always_comb begin
    fp_d      = fp_q;
    pp_d      = pp_q;
    bl_d      = bl_q;
    pl_d      = pl_q;
    tag_d     = tag_q;
    hv_d      = hv_q;
    idx_d     = idx_q;
    tot_d     = tot_q;
    key_d     = key_q;
    whole_d   = whole_q;
    pc_d      = pc_q;
    rc_d      = rc_q;
    err_d     = err_q;
    start_en  = 1'b0;
    start_len = '0;
    fin       = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_PAYLOAD;
    off       = pl_q - bl_q;
    st        = ST_OK;

    if (err_q == ST_OK && fp_q < FP_DONE) begin
      case (pp_q)
        PP_OP: begin
          if (script_byte_i <= OP_DIRECT_MAX) begin
            start_en  = 1'b1;
            start_len = {8'h00, script_byte_i};
          end else if (script_byte_i == OP_LEN8) begin
            pp_d = PP_LEN;
            bl_d = '0;
          end else if (script_byte_i == OP_LEN16) begin
            pp_d = PP_LEN;
            bl_d = 16'd1;
          end else begin
            err_d = ST_BAD_OP;
          end
        end
        PP_LEN: begin
          if (bl_q == 16'd1) begin
            pl_d = {8'h00, script_byte_i};
            bl_d = '0;
            pp_d = PP_HI;
          end else begin
            start_en  = 1'b1;
            start_len = {8'h00, script_byte_i};
          end
        end
        PP_HI: begin
          start_en  = 1'b1;
          start_len = {script_byte_i, pl_q[7:0]};
        end
        PP_DATA: begin
          if (fp_q == FP_TAG) begin
            if (off < FIELD_LEN) tag_d = {tag_q[55:0], script_byte_i};
          end else if (fp_q == FP_HDR) begin
            if (off < FIELD_LEN) begin
              case (off[2:0])
                3'd0:    hv_d = script_byte_i;
                3'd1:    idx_d = script_byte_i;
                3'd2:    tot_d = script_byte_i;
                3'd4:    key_d = {script_byte_i, key_q[7:0]};
                3'd5:    key_d = {key_q[15:8], script_byte_i};
                3'd6:    whole_d = {script_byte_i, whole_q[7:0]};
                3'd7:    whole_d = {whole_q[15:8], script_byte_i};
                default: ;
              endcase
            end
          end else if (fp_q < FP_REDEEM) begin
            if (pl_q <= CHUNK_LIMIT) begin
              emit      = 1'b1;
              emit_kind = KIND_PAYLOAD;
              pc_d      = pc_q + 12'd1;
            end
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_REDEEM;
            rc_d      = rc_q + 16'd1;
          end
          bl_d = bl_q - 16'd1;
          if (bl_d == '0) fin = 1'b1;
        end
        default: ;
      endcase
    end

    if (start_en) begin
      pl_d = start_len;
      bl_d = start_len;
      if (start_len == '0) fin = 1'b1;
      else pp_d = PP_DATA;
    end

    if (fin) begin
      pp_d = PP_OP;
      bl_d = '0;
      if (fp_q == FP_TAG) begin
        if (pl_d != FIELD_LEN) err_d = ST_TAG_LEN;
        else fp_d = FP_HDR;
      end else if (fp_q == FP_HDR) begin
        if (pl_d != FIELD_LEN) err_d = ST_HDR_LEN;
        else if (hv_d != HDR_VERSION) err_d = ST_VERSION;
        else fp_d = FP_CHUNK0;
      end else if (fp_q < FP_REDEEM) begin
        if (pl_d > CHUNK_LIMIT) err_d = ST_CHUNK_LONG;
        else fp_d = fp_q + FP_ONE;
      end else begin
        fp_d = FP_DONE;
      end
    end

    st = err_d;
    if (err_d == ST_OK && fp_d < FP_DONE) st = ST_TRUNC;

    entry_o.data_vld  = emit;
    entry_o.data_kind = emit_kind;
    entry_o.data_byte = script_byte_i;
    entry_o.sum_vld   = end_of_script_i;
    entry_o.tag       = tag_d;
    entry_o.part      = idx_d;
    entry_o.parts     = tot_d;
    entry_o.key_len   = key_d;
    entry_o.whole_len = whole_d;
    entry_o.pay_cnt   = pc_d;
    entry_o.red_cnt   = rc_d;
    entry_o.status    = st;

    if (end_of_script_i) begin
      fp_d    = FP_TAG;
      pp_d    = PP_OP;
      bl_d    = '0;
      pl_d    = '0;
      tag_d   = '0;
      hv_d    = '0;
      idx_d   = '0;
      tot_d   = '0;
      key_d   = '0;
      whole_d = '0;
      pc_d    = '0;
      rc_d    = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q    <= FP_TAG;
      pp_q    <= PP_OP;
      bl_q    <= '0;
      pl_q    <= '0;
      tag_q   <= '0;
      hv_q    <= '0;
      idx_q   <= '0;
      tot_q   <= '0;
      key_q   <= '0;
      whole_q <= '0;
      pc_q    <= '0;
      rc_q    <= '0;
      err_q   <= ST_OK;
    end else if (acc) begin
      fp_q    <= fp_d;
      pp_q    <= pp_d;
      bl_q    <= bl_d;
      pl_q    <= pl_d;
      tag_q   <= tag_d;
      hv_q    <= hv_d;
      idx_q   <= idx_d;
      tot_q   <= tot_d;
      key_q   <= key_d;
      whole_q <= whole_d;
      pc_q    <= pc_d;
      rc_q    <= rc_d;
      err_q   <= err_d;
    end
  end

endmodule

>>> hw/rtl/cspp_fifo.sv
`include "carrier_script_part_parser_defines.svh"

module cspp_fifo
  import cspp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output q_stat_t  stat_o
);

  q_entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);
  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);

  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + QCNT_W'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + QPTR_W'(1);
      if (pop_i) rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + QPTR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `CSPP_ASSERT(a_no_push_full, !(push_i && stat_o.full && !pop_i), "push into full queue")
  `CSPP_ASSERT(a_no_pop_empty, !(pop_i && stat_o.empty), "pop from empty queue")
  `CSPP_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + QCNT_W'(1), "count lost a push")
  `CSPP_ASSERT(a_entry_nonempty, !push_i || push_data_i.data_vld || push_data_i.sum_vld, "empty entry queued")

endmodule

>>> hw/rtl/cspp_back.sv
module cspp_back
  import cspp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_entry_t    head_i,
  input  q_stat_t     q_stat_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [63:0] tag_word_o,
  output logic [7:0]  part_number_o,
  output logic [7:0]  parts_in_all_o,
  output logic [15:0] key_length_o,
  output logic [15:0] whole_length_o,
  output logic [11:0] payload_count_o,
  output logic [15:0] redeem_count_o,
  output logic [2:0]  status_o,
  output logic        final_result_o
);

  logic out_valid_q;
  logic sent_q;
  logic load;
  logic take;
  logic send_data;

  assign load      = !out_valid_q || out_ready_i;
  assign take      = load && !q_stat_i.empty;
  assign send_data = head_i.data_vld && !sent_q;
  assign pop_o     = take && !(send_data && head_i.sum_vld);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= 1'b0;
    end else if (load) begin
      out_valid_q <= !q_stat_i.empty;
      if (take) sent_q <= send_data && head_i.sum_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (send_data) begin
        kind_o          <= head_i.data_kind;
        data_byte_o     <= head_i.data_byte;
        tag_word_o      <= '0;
        part_number_o   <= '0;
        parts_in_all_o  <= '0;
        key_length_o    <= '0;
        whole_length_o  <= '0;
        payload_count_o <= '0;
        redeem_count_o  <= '0;
        status_o        <= ST_OK;
        final_result_o  <= 1'b0;
      end else begin
        kind_o          <= KIND_SUMMARY;
        data_byte_o     <= '0;
        tag_word_o      <= head_i.tag;
        part_number_o   <= head_i.part;
        parts_in_all_o  <= head_i.parts;
        key_length_o    <= head_i.key_len;
        whole_length_o  <= head_i.whole_len;
        payload_count_o <= head_i.pay_cnt;
        redeem_count_o  <= head_i.red_cnt;
        status_o        <= head_i.status;
        final_result_o  <= 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/carrier_script_part_parser.sv
// channel  handshake               payload
// in       in_valid_i/in_ready_o   script_byte_i, end_of_script_i
// out      out_valid_o/out_ready_i kind_o, data_byte_o, summary fields, final_result_o
//
// one byte per clock while in_ready_o is high; parser state updates when it is taken
// a result is queued as its byte is taken and then moves into the output register
// a last script byte that also streams a payload or redeem byte yields two beats,
// and its queue entry is popped only with the second
// in_ready_o drops only when the four-entry queue between parser and output is full
// asynchronous active-low reset clears parser state, queue and output valid
module carrier_script_part_parser
  import cspp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  script_byte_i,
  input  logic        end_of_script_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [63:0] tag_word_o,
  output logic [7:0]  part_number_o,
  output logic [7:0]  parts_in_all_o,
  output logic [15:0] key_length_o,
  output logic [15:0] whole_length_o,
  output logic [11:0] payload_count_o,
  output logic [15:0] redeem_count_o,
  output logic [2:0]  status_o,
  output logic        final_result_o
);

  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;

  cspp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .script_byte_i   (script_byte_i),
    .end_of_script_i (end_of_script_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  cspp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  cspp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .q_stat_i        (q_stat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .tag_word_o      (tag_word_o),
    .part_number_o   (part_number_o),
    .parts_in_all_o  (parts_in_all_o),
    .key_length_o    (key_length_o),
    .whole_length_o  (whole_length_o),
    .payload_count_o (payload_count_o),
    .redeem_count_o  (redeem_count_o),
    .status_o        (status_o),
    .final_result_o  (final_result_o)
  );

endmodule

>>> bench/tb_carrier_script_part_parser.sv
module tb_carrier_script_part_parser;
  import cspp_pkg::*;

  localparam logic [7:0] OP_LEN8      = 8'h4c;
  localparam logic [7:0] OP_LEN16     = 8'h4d;
  localparam logic [7:0] MAX_DIRECT   = 8'd75;
  localparam logic [7:0] HDR_VERSION  = 8'h01;

  localparam int FIELD_TAG    = 0;
  localparam int FIELD_HDR    = 1;
  localparam int FIELD_CHUNK0 = 2;
  localparam int FIELD_REDEEM = 2 + CHUNK_COUNT;
  localparam int FIELD_DONE   = 3 + CHUNK_COUNT;

  localparam int RANDOM_BEATS = 650;

  typedef enum logic [1:0] {
    PP_OPCODE,
    PP_LEN,
    PP_LEN_HI,
    PP_DATA
  } push_phase_e;

  typedef enum int {
    ENC_MIN,
    ENC_PD1,
    ENC_PD2
  } push_enc_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  dbyte;
    logic [63:0] tag;
    logic [7:0]  part;
    logic [7:0]  parts;
    logic [15:0] klen;
    logic [15:0] wlen;
    logic [11:0] pcnt;
    logic [15:0] rcnt;
    status_e     status;
    logic        fin;
  } parser_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  script_byte_i;
  logic        end_of_script_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [63:0] tag_word_o;
  logic [7:0]  part_number_o;
  logic [7:0]  parts_in_all_o;
  logic [15:0] key_length_o;
  logic [15:0] whole_length_o;
  logic [11:0] payload_count_o;
  logic [15:0] redeem_count_o;
  logic [2:0]  status_o;
  logic        final_result_o;

  // parser prediction state
  int          fld_phase;
  push_phase_e psh_phase;
  logic [15:0] psh_left;
  logic [15:0] psh_len;
  logic [63:0] tag_acc;
  logic [7:0]  hdr_ver;
  logic [7:0]  part_acc;
  logic [7:0]  parts_acc;
  logic [15:0] klen_acc;
  logic [15:0] wlen_acc;
  logic [11:0] payload_bytes;
  logic [15:0] redeem_bytes;
  status_e     parse_err;

  parser_beat_t pending_beats[$];
  logic [7:0]   script_q[$];
  logic [7:0]   body_q[$];

  int mismatches;
  int beats_sent;
  bit calm;

  carrier_script_part_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .script_byte_i   (script_byte_i),
    .end_of_script_i (end_of_script_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .tag_word_o      (tag_word_o),
    .part_number_o   (part_number_o),
    .parts_in_all_o  (parts_in_all_o),
    .key_length_o    (key_length_o),
    .whole_length_o  (whole_length_o),
    .payload_count_o (payload_count_o),
    .redeem_count_o  (redeem_count_o),
    .status_o        (status_o),
    .final_result_o  (final_result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic parse_clear();
    fld_phase     = FIELD_TAG;
    psh_phase     = PP_OPCODE;
    psh_left      = '0;
    psh_len       = '0;
    tag_acc       = '0;
    hdr_ver       = '0;
    part_acc      = '0;
    parts_acc     = '0;
    klen_acc      = '0;
    wlen_acc      = '0;
    payload_bytes = '0;
    redeem_bytes  = '0;
    parse_err     = ST_OK;
  endtask

  task automatic push_done();
    psh_phase = PP_OPCODE;
    psh_left  = '0;
    if (fld_phase == FIELD_TAG) begin
      if (psh_len != 16'd8) parse_err = ST_TAG_LEN;
      else fld_phase = FIELD_HDR;
    end else if (fld_phase == FIELD_HDR) begin
      if (psh_len != 16'd8) parse_err = ST_HDR_LEN;
      else if (hdr_ver != HDR_VERSION) parse_err = ST_VERSION;
      else fld_phase = FIELD_CHUNK0;
    end else if (fld_phase < FIELD_REDEEM) begin
      if (psh_len > CHUNK_LIMIT) parse_err = ST_CHUNK_LONG;
      else fld_phase++;
    end else begin
      fld_phase = FIELD_DONE;
    end
  endtask

  task automatic push_open(input logic [15:0] len);
    psh_len  = len;
    psh_left = len;
    if (len == 16'd0) push_done();
    else psh_phase = PP_DATA;
  endtask

  task automatic expect_data(input kind_e kind, input logic [7:0] b);
    parser_beat_t r;
    r       = '0;
    r.kind  = kind;
    r.dbyte = b;
    pending_beats.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b);
    logic [15:0] off;
    off = psh_len - psh_left;
    if (fld_phase == FIELD_TAG) begin
      if (off < 16'd8) tag_acc = {tag_acc[55:0], b};
    end else if (fld_phase == FIELD_HDR) begin
      if (off < 16'd8) begin
        case (off[2:0])
          3'd0: hdr_ver = b;
          3'd1: part_acc = b;
          3'd2: parts_acc = b;
          3'd4: klen_acc[15:8] = b;
          3'd5: klen_acc[7:0] = b;
          3'd6: wlen_acc[15:8] = b;
          3'd7: wlen_acc[7:0] = b;
          default: ;
        endcase
      end
    end else if (fld_phase < FIELD_REDEEM) begin
      if (psh_len <= CHUNK_LIMIT) begin
        expect_data(KIND_PAYLOAD, b);
        payload_bytes++;
      end
    end else begin
      expect_data(KIND_REDEEM, b);
      redeem_bytes++;
    end
    psh_left--;
    if (psh_left == 16'd0) push_done();
  endtask

  task automatic parse_predict(input logic [7:0] b, input logic last);
    parser_beat_t r;
    if (parse_err == ST_OK && fld_phase < FIELD_DONE) begin
      case (psh_phase)
        PP_OPCODE: begin
          if (b <= MAX_DIRECT) push_open({8'h00, b});
          else if (b == OP_LEN8) begin
            psh_phase = PP_LEN;
            psh_left  = 16'd0;
          end else if (b == OP_LEN16) begin
            psh_phase = PP_LEN;
            psh_left  = 16'd1;
          end else parse_err = ST_BAD_OP;
        end
        PP_LEN: begin
          if (psh_left == 16'd1) begin
            psh_len   = {8'h00, b};
            psh_left  = 16'd0;
            psh_phase = PP_LEN_HI;
          end else push_open({8'h00, b});
        end
        PP_LEN_HI: push_open({b, psh_len[7:0]});
        default: push_byte(b);
      endcase
    end
    if (last) begin
      r        = '0;
      r.kind   = KIND_SUMMARY;
      r.tag    = tag_acc;
      r.part   = part_acc;
      r.parts  = parts_acc;
      r.klen   = klen_acc;
      r.wlen   = wlen_acc;
      r.pcnt   = payload_bytes;
      r.rcnt   = redeem_bytes;
      r.status = (parse_err == ST_OK && fld_phase < FIELD_DONE) ? ST_TRUNC : parse_err;
      r.fin    = 1'b1;
      pending_beats.push_back(r);
      parse_clear();
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h", what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk_i) begin
    parser_beat_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_beats.size() == 0) begin
        note_mismatch("unexpected beat, kind", '0, kind_o);
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("data_byte", want.dbyte, data_byte_o);
        check_field("tag_word", want.tag, tag_word_o);
        check_field("part_number", want.part, part_number_o);
        check_field("parts_in_all", want.parts, parts_in_all_o);
        check_field("key_length", want.klen, key_length_o);
        check_field("whole_length", want.wlen, whole_length_o);
        check_field("payload_count", want.pcnt, payload_count_o);
        check_field("redeem_count", want.rcnt, redeem_count_o);
        check_field("status", want.status, status_o);
        check_field("final_result", want.fin, final_result_o);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i = calm || ($urandom_range(0, 99) >= 6);
  end

  // entered and left at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    if (!calm && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 3);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    script_byte_i   = b;
    end_of_script_i = last;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    parse_predict(b, last);
    beats_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_script(input int keep);
    int n;
    n = (keep > script_q.size()) ? script_q.size() : keep;
    for (int i = 0; i < n; i++) send_beat(script_q[i], i == n - 1);
    script_q.delete();
  endtask

  task automatic emit_push(input push_enc_e enc);
    int n;
    n = body_q.size();
    if (enc == ENC_PD2 || n > 255) begin
      script_q.push_back(OP_LEN16);
      script_q.push_back(n[7:0]);
      script_q.push_back(n[15:8]);
    end else if (enc == ENC_PD1 || n > MAX_DIRECT) begin
      script_q.push_back(OP_LEN8);
      script_q.push_back(n[7:0]);
    end else begin
      script_q.push_back(n[7:0]);
    end
    foreach (body_q[i]) script_q.push_back(body_q[i]);
    body_q.delete();
  endtask

  task automatic add_random_push(input int n, input push_enc_e enc);
    repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    emit_push(enc);
  endtask

  task automatic add_header(input int n, input logic [7:0] ver, input push_enc_e enc);
    for (int i = 0; i < n; i++)
      body_q.push_back(i == 0 ? ver : 8'($urandom_range(0, 255)));
    emit_push(enc);
  endtask

  function automatic push_enc_e any_enc();
    return push_enc_e'($urandom_range(0, 2));
  endfunction

  task automatic build_script(input int tag_n, input int hdr_n, input logic [7:0] ver,
                              input int max_chunk, input int redeem_n, input int tail_n);
    int len;
    add_random_push(tag_n, any_enc());
    add_header(hdr_n, ver, any_enc());
    repeat (CHUNK_COUNT) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(76, 90)
                                         : $urandom_range(0, max_chunk);
      add_random_push(len, any_enc());
    end
    add_random_push(redeem_n, any_enc());
    repeat (tail_n) script_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_bad_opcode();
    script_q.push_back(8'h4e);
    send_script(1);
    add_random_push(8, ENC_MIN);
    script_q.push_back(8'hff);
    script_q.push_back(8'h05);
    script_q.push_back(8'h00);
    send_script(script_q.size());
  endtask

  task automatic test_truncation();
    add_random_push(8, ENC_MIN);
    send_script(4);
    script_q.push_back(OP_LEN8);
    send_script(1);
    script_q.push_back(OP_LEN16);
    script_q.push_back(8'h10);
    send_script(2);
    build_script(8, 8, HDR_VERSION, 6, 4, 0);
    send_script(script_q.size() - 3);
  endtask

  task automatic test_field_lengths();
    add_random_push(0, ENC_MIN);
    script_q.push_back(8'h00);
    send_script(script_q.size());
    build_script(9, 8, HDR_VERSION, 2, 2, 0);
    send_script(script_q.size());
    build_script(8, 7, HDR_VERSION, 2, 2, 0);
    send_script(script_q.size());
    build_script(8, 8, 8'h00, 2, 2, 0);
    send_script(script_q.size());
    build_script(8, 8, 8'hff, 2, 2, 0);
    send_script(script_q.size());
  endtask

  task automatic test_chunk_extremes();
    add_random_push(8, ENC_PD1);
    add_header(8, HDR_VERSION, ENC_PD2);
    add_random_push(0, ENC_MIN);
    add_random_push(1, ENC_MIN);
    add_random_push(int'(MAX_DIRECT), ENC_MIN);
    add_random_push(int'(MAX_DIRECT) + 1, ENC_MIN);
    add_random_push(int'(CHUNK_LIMIT), ENC_PD2);
    add_random_push(3, ENC_PD2);
    script_q.push_back(8'h4e);
    script_q.push_back(8'hff);
    send_script(script_q.size());
    // oversized chunk streams nothing and fails once complete
    add_random_push(8, ENC_MIN);
    add_header(8, HDR_VERSION, ENC_MIN);
    add_random_push(2, ENC_PD1);
    add_random_push(int'(CHUNK_LIMIT) + 1, ENC_PD2);
    add_random_push(2, ENC_MIN);
    send_script(script_q.size());
  endtask

  task automatic test_random_scripts();
    int first;
    int pick;
    int size;
    first = beats_sent;
    while (beats_sent - first < RANDOM_BEATS) begin
      calm = (beats_sent - first >= 250) && (beats_sent - first < 400);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_script(8, 8, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                       : HDR_VERSION,
                     10, $urandom_range(0, 16),
                     ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0);
      end else if (pick < 85) begin
        build_script($urandom_range(0, 11), $urandom_range(0, 11), HDR_VERSION,
                     6, $urandom_range(0, 6), 0);
      end else begin
        repeat ($urandom_range(1, 8)) script_q.push_back(8'($urandom_range(0, 255)));
      end
      size = script_q.size();
      if ($urandom_range(0, 4) == 0) size = $urandom_range(1, size);
      send_script(size);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    script_byte_i   = '0;
    end_of_script_i = 1'b0;
    out_ready_i     = 1'b0;
    mismatches      = 0;
    beats_sent      = 0;
    calm            = 1'b0;
    parse_clear();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_bad_opcode();
    test_truncation();
    test_field_lengths();
    test_chunk_extremes();
    test_random_scripts();

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("tb_carrier_script_part_parser: done, clean");
    end else begin
      $display("tb_carrier_script_part_parser: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_carrier_script_part_parser: done, errors");
    $finish;
  end

endmodule
